>>> rtl/core/pgwb_pkg.sv
`default_nettype none

package pgwb_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int MAX_GRID    = 256;

  localparam int WK_W   = $clog2(MAX_WORKERS);
  localparam int WC_W   = $clog2(MAX_WORKERS + 1);
  localparam int CELL_W = $clog2(MAX_GRID);
  localparam int GRID_W = 9;
  localparam int CNT_W  = 16;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_CELL_W_X    = 3'd2;
  localparam logic [2:0] REG_CELL_W_Y    = 3'd3;
  localparam logic [2:0] REG_GRID_SIZE   = 3'd4;
  localparam logic [2:0] REG_WORKER_CNT  = 3'd5;
  localparam logic [2:0] REG_BATCH_LIMIT = 3'd6;

  // Operand selection for the shared divider.
  typedef enum logic [2:0] {
    DIV_MIN_X = 3'd0,
    DIV_MIN_Y = 3'd1,
    DIV_MAX_X = 3'd2,
    DIV_MAX_Y = 3'd3,
    DIV_BASE  = 3'd4,
    DIV_GMOD  = 3'd5
  } div_sel_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DSTART = 8'b0000_0010,
    S_DWAIT  = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_ERR    = 8'b0001_0000,
    S_WINIT  = 8'b0010_0000,
    S_WALK   = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic     box_upd;
    logic     box_clr;
    logic     latch_id;
    logic     flush_load;
    logic     div_start;
    logic     div_store;
    div_sel_t div_sel;
    logic     walk_init;
    logic     walk_step;
    logic     emit_go;
    logic     err_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic corners_ok;
    logic walk_last;
    logic marks_empty;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/pgwb_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pgwb_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [30:0] divisor,
  output logic             done,
  output logic [31:0]      quo,
  output logic [30:0]      rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [30:0] dsr;
  logic [31:0] trial;
  logic [31:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, quo[31]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[30:0], ge};
      rem <= ge ? diff[30:0] : trial[30:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pgwb_dp.sv
`default_nettype none

module pgwb_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [31:0]         polygon_id,
  input  wire logic signed [31:0]  vertex_x,
  input  wire logic signed [31:0]  vertex_y,
  input  wire pgwb_pkg::cmd_t      cmd,
  output pgwb_pkg::stat_t          stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              out_polygon_id,
  output logic [3:0]               worker,
  output logic                     flush,
  output logic [15:0]              batch_count,
  output logic                     status,
  output logic                     last
);

  localparam int MW = pgwb_pkg::MAX_WORKERS;
  localparam int WW = pgwb_pkg::WK_W;
  localparam int WC = pgwb_pkg::WC_W;
  localparam int CW = pgwb_pkg::CELL_W;
  localparam int GW = pgwb_pkg::GRID_W;
  localparam int NW = pgwb_pkg::CNT_W;
  localparam logic signed [31:0] BOX_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] BOX_NEG = 32'sh8000_0000;

  logic signed [31:0] origin_x, origin_y;
  logic [30:0] cell_width_x, cell_width_y;
  logic [8:0]  grid_size;
  logic [4:0]  worker_count;
  logic [15:0] batch_limit;

  logic signed [31:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic [NW-1:0] counts [MW];
  logic [MW-1:0] marks;
  logic [WW-1:0] ptr;
  logic          flush_mode;
  logic [31:0]   id_reg;

  logic [CW-1:0] x0, y0, x1, y1;
  logic          ok;
  logic          dvd_neg;
  logic [WW-1:0] rem_base, rem_gmod;

  logic [WW-1:0] res, rrow;
  logic [WW-1:0] col, row, nx_m1, ny_m1;

  logic [GW-1:0] g_eff;
  logic [WC-1:0] w_eff;
  logic [30:0]   cwx_eff, cwy_eff;

  logic          div_start;
  logic [31:0]   div_dvd;
  logic [30:0]   div_dsr;
  logic          div_neg;
  logic          div_done;
  logic [31:0]   div_quo;
  logic [30:0]   div_rem;

  logic signed [32:0] diff;
  logic        cell_ok;
  logic [CW-1:0] cell_idx;
  logic [GW:0] span_x, span_y;
  logic [WC:0] res_inc, row_sum;
  logic [WW-1:0] res_next, rrow_next;
  logic [NW:0]   cnt_inc;
  logic          emit_load;
  logic          out_free;

  always_comb begin
    g_eff   = (grid_size > GW'(pgwb_pkg::MAX_GRID)) ? GW'(pgwb_pkg::MAX_GRID) : grid_size;
    w_eff   = (worker_count == '0) ? WC'(1) :
              (worker_count > 5'(MW)) ? WC'(MW) : WC'(worker_count);
    cwx_eff = (cell_width_x == '0) ? 31'd1 : cell_width_x;
    cwy_eff = (cell_width_y == '0) ? 31'd1 : cell_width_y;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_width_x <= 31'd256;
      cell_width_y <= 31'd256;
      grid_size    <= 9'd16;
      worker_count <= 5'd4;
      batch_limit  <= 16'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        pgwb_pkg::REG_ORIGIN_X:    origin_x     <= cfg_data;
        pgwb_pkg::REG_ORIGIN_Y:    origin_y     <= cfg_data;
        pgwb_pkg::REG_CELL_W_X:    cell_width_x <= cfg_data[30:0];
        pgwb_pkg::REG_CELL_W_Y:    cell_width_y <= cfg_data[30:0];
        pgwb_pkg::REG_GRID_SIZE:   grid_size    <= cfg_data[8:0];
        pgwb_pkg::REG_WORKER_CNT:  worker_count <= cfg_data[4:0];
        pgwb_pkg::REG_BATCH_LIMIT: batch_limit  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Running bounding box.
  always_ff @(posedge clk) begin
    if (rst || cmd.box_clr) begin
      box_min_x <= BOX_POS;
      box_min_y <= BOX_POS;
      box_max_x <= BOX_NEG;
      box_max_y <= BOX_NEG;
    end else if (cmd.box_upd) begin
      if (vertex_x < box_min_x) box_min_x <= vertex_x;
      if (vertex_y < box_min_y) box_min_y <= vertex_y;
      if (vertex_x > box_max_x) box_max_x <= vertex_x;
      if (vertex_y > box_max_y) box_max_y <= vertex_y;
    end
  end

  // Divider operand selection.
  always_comb begin
    diff    = '0;
    div_dvd = '0;
    div_dsr = 31'd1;
    div_neg = 1'b0;
    case (cmd.div_sel)
      pgwb_pkg::DIV_MIN_X: begin
        diff    = {box_min_x[31], box_min_x} - {origin_x[31], origin_x};
        div_dsr = cwx_eff;
      end
      pgwb_pkg::DIV_MIN_Y: begin
        diff    = {box_min_y[31], box_min_y} - {origin_y[31], origin_y};
        div_dsr = cwy_eff;
      end
      pgwb_pkg::DIV_MAX_X: begin
        diff    = {box_max_x[31], box_max_x} - {origin_x[31], origin_x};
        div_dsr = cwx_eff;
      end
      pgwb_pkg::DIV_MAX_Y: begin
        diff    = {box_max_y[31], box_max_y} - {origin_y[31], origin_y};
        div_dsr = cwy_eff;
      end
      pgwb_pkg::DIV_BASE: begin
        div_dsr = 31'(w_eff);
      end
      pgwb_pkg::DIV_GMOD: begin
        div_dsr = 31'(w_eff);
      end
      default: ;
    endcase
    if (cmd.div_sel == pgwb_pkg::DIV_BASE) begin
      div_dvd = 32'(16'(y0) * 16'(g_eff)) + 32'(x0);
    end else if (cmd.div_sel == pgwb_pkg::DIV_GMOD) begin
      div_dvd = 32'(g_eff);
    end else begin
      div_neg = diff[32];
      div_dvd = div_neg ? 32'(-diff) : diff[31:0];
    end
  end

  assign div_start = cmd.div_start;

  pgwb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // A negative offset smaller than one cell truncates to cell zero.
  always_comb begin
    cell_ok  = dvd_neg ? (div_quo == '0) : (div_quo < 32'(g_eff));
    cell_idx = dvd_neg ? '0 : div_quo[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) dvd_neg <= div_neg;
    if (cmd.div_store) begin
      case (cmd.div_sel)
        pgwb_pkg::DIV_MIN_X: begin x0 <= cell_idx; ok <= cell_ok; end
        pgwb_pkg::DIV_MIN_Y: begin y0 <= cell_idx; ok <= ok & cell_ok; end
        pgwb_pkg::DIV_MAX_X: begin x1 <= cell_idx; ok <= ok & cell_ok; end
        pgwb_pkg::DIV_MAX_Y: begin y1 <= cell_idx; ok <= ok & cell_ok; end
        pgwb_pkg::DIV_BASE:  rem_base <= div_rem[WW-1:0];
        pgwb_pkg::DIV_GMOD:  rem_gmod <= div_rem[WW-1:0];
        default: ;
      endcase
    end
    if (cmd.latch_id) id_reg <= polygon_id;
  end

  // Worker ids repeat with period w in each axis, so at most w columns and
  // w rows need a visit.
  always_comb begin
    span_x    = {1'b0, GW'(x1) - GW'(x0)};
    span_y    = {1'b0, GW'(y1) - GW'(y0)};
    res_inc   = {1'b0, res} + 1'b1;
    res_next  = (res_inc[WC-1:0] == w_eff) ? '0 : res_inc[WW-1:0];
    row_sum   = {1'b0, rrow} + {1'b0, rem_gmod};
    rrow_next = (row_sum >= {1'b0, w_eff}) ? WW'(row_sum - {1'b0, w_eff}) : row_sum[WW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      res   <= rem_base;
      rrow  <= rem_base;
      col   <= '0;
      row   <= '0;
      nx_m1 <= (span_x >= GW'(w_eff)) ? WW'(w_eff - 1'b1) : span_x[WW-1:0];
      ny_m1 <= (span_y >= GW'(w_eff)) ? WW'(w_eff - 1'b1) : span_y[WW-1:0];
    end else if (cmd.walk_step) begin
      if (col == nx_m1) begin
        col  <= '0;
        row  <= row + 1'b1;
        rrow <= rrow_next;
        res  <= rrow_next;
      end else begin
        col <= col + 1'b1;
        res <= res_next;
      end
    end
  end

  // Result emission.
  assign out_free  = !out_valid || out_ready;
  assign emit_load = cmd.emit_go && marks[ptr] && out_free;
  assign cnt_inc   = {1'b0, counts[ptr]} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks      <= '0;
      ptr        <= '0;
      flush_mode <= 1'b0;
      for (int i = 0; i < MW; i++) counts[i] <= '0;
    end else begin
      if (cmd.flush_load) begin
        for (int i = 0; i < MW; i++) marks[i] <= (counts[i] != '0);
        ptr        <= '0;
        flush_mode <= 1'b1;
      end else if (cmd.walk_init) begin
        marks      <= '0;
        ptr        <= '0;
        flush_mode <= 1'b0;
      end else if (cmd.walk_step) begin
        marks[res] <= 1'b1;
      end else if (cmd.emit_go) begin
        if (emit_load) begin
          marks[ptr] <= 1'b0;
          ptr        <= ptr + 1'b1;
          if (flush_mode || cnt_inc >= {1'b0, batch_limit}) counts[ptr] <= '0;
          else counts[ptr] <= cnt_inc[NW-1:0];
        end else if (!marks[ptr]) begin
          ptr <= ptr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load || (cmd.err_load && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_polygon_id <= flush_mode ? '0 : id_reg;
      worker         <= ptr;
      flush          <= flush_mode || (cnt_inc >= {1'b0, batch_limit});
      batch_count    <= flush_mode ? counts[ptr] : cnt_inc[NW-1:0];
      status         <= 1'b0;
      last           <= ((marks >> ptr) == MW'(1));
    end else if (cmd.err_load && out_free) begin
      out_polygon_id <= id_reg;
      worker         <= '0;
      flush          <= 1'b0;
      batch_count    <= '0;
      status         <= 1'b1;
      last           <= 1'b1;
    end
  end

  always_comb begin
    stat.div_done    = div_done;
    stat.corners_ok  = ok;
    stat.walk_last   = (col == nx_m1) && (row == ny_m1);
    stat.marks_empty = (marks == '0);
    stat.out_free    = out_free;
  end

  a_walk_res: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> (WC'(res) < w_eff))
    else $error("walk residue outside worker range");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (emit_load && ((marks >> ptr) == MW'(1))) |=> (marks == '0))
    else $error("marks remain after final result");

  a_flush_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flush) |-> (batch_count != '0))
    else $error("flush of an empty batch");

endmodule

`default_nettype wire

>>> rtl/core/pgwb_ctrl.sv
`default_nettype none

module pgwb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            kind,
  input  wire logic            last_vertex,
  output logic                 in_ready,
  input  wire pgwb_pkg::stat_t stat,
  output pgwb_pkg::cmd_t       cmd
);

  pgwb_pkg::state_t   state, state_next;
  pgwb_pkg::div_sel_t sel, sel_next;
  logic               accept;

  assign in_ready = (state == pgwb_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    cmd            = '0;
    cmd.div_sel    = sel;
    case (state)
      pgwb_pkg::S_IDLE: begin
        if (accept) begin
          if (kind) begin
            cmd.flush_load = 1'b1;
            cmd.box_clr    = 1'b1;
            state_next     = pgwb_pkg::S_EMIT;
          end else begin
            cmd.box_upd = 1'b1;
            if (last_vertex) begin
              cmd.latch_id = 1'b1;
              sel_next     = pgwb_pkg::DIV_MIN_X;
              state_next   = pgwb_pkg::S_DSTART;
            end
          end
        end
      end
      pgwb_pkg::S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = pgwb_pkg::S_DWAIT;
      end
      pgwb_pkg::S_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          case (sel)
            pgwb_pkg::DIV_MIN_X: begin
              sel_next = pgwb_pkg::DIV_MIN_Y; state_next = pgwb_pkg::S_DSTART;
            end
            pgwb_pkg::DIV_MIN_Y: begin
              sel_next = pgwb_pkg::DIV_MAX_X; state_next = pgwb_pkg::S_DSTART;
            end
            pgwb_pkg::DIV_MAX_X: begin
              sel_next = pgwb_pkg::DIV_MAX_Y; state_next = pgwb_pkg::S_DSTART;
            end
            pgwb_pkg::DIV_MAX_Y: state_next = pgwb_pkg::S_CHECK;
            pgwb_pkg::DIV_BASE: begin
              sel_next = pgwb_pkg::DIV_GMOD; state_next = pgwb_pkg::S_DSTART;
            end
            default: state_next = pgwb_pkg::S_WINIT;
          endcase
        end
      end
      pgwb_pkg::S_CHECK: begin
        cmd.box_clr = 1'b1;
        if (stat.corners_ok) begin
          sel_next   = pgwb_pkg::DIV_BASE;
          state_next = pgwb_pkg::S_DSTART;
        end else begin
          state_next = pgwb_pkg::S_ERR;
        end
      end
      pgwb_pkg::S_ERR: begin
        cmd.err_load = 1'b1;
        if (stat.out_free) state_next = pgwb_pkg::S_IDLE;
      end
      pgwb_pkg::S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_next    = pgwb_pkg::S_WALK;
      end
      pgwb_pkg::S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) state_next = pgwb_pkg::S_EMIT;
      end
      pgwb_pkg::S_EMIT: begin
        if (stat.marks_empty) state_next = pgwb_pkg::S_IDLE;
        else cmd.emit_go = 1'b1;
      end
      default: state_next = pgwb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgwb_pkg::S_IDLE;
      sel   <= pgwb_pkg::DIV_MIN_X;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  a_start_from_wait: assert property (@(posedge clk) disable iff (rst)
    (state == pgwb_pkg::S_DSTART) |=> (state == pgwb_pkg::S_DWAIT))
    else $error("divider start not followed by wait");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && !kind && !last_vertex) |=> (state == pgwb_pkg::S_IDLE))
    else $error("inner vertex left idle");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (state == pgwb_pkg::S_ERR && stat.out_free) |=> (state == pgwb_pkg::S_IDLE))
    else $error("error result not single");

endmodule

`default_nettype wire

>>> rtl/core/polygon_grid_worker_batcher.sv
// Channel   Direction  Handshake               Content
// in        input      in_valid / in_ready     kind, polygon_id, vertex_x/_y, last_vertex
// out       output     out_valid / out_ready   out_polygon_id, worker, flush, batch_count,
//                                              status, last
// cfg       input      cfg_write               cfg_index, cfg_data
//
// A vertex that does not close its polygon is taken without leaving idle. A closing vertex
// runs four divisions on the shared restoring divider; if all corners lie in the grid, two
// more, a cell walk of at most w columns and w rows and an emission pass follow, else an
// error result. An end item flushes each worker with a nonzero batch count. Reset is
// synchronous and clears the control state, the batch counts and the box. A stalled output
// holds the finished result in its register while further results wait in emit or error.
`default_nettype none

module polygon_grid_worker_batcher (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [31:0]        polygon_id,
  input  wire logic signed [31:0] vertex_x,
  input  wire logic signed [31:0] vertex_y,
  input  wire logic               last_vertex,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             out_polygon_id,
  output logic [3:0]              worker,
  output logic                    flush,
  output logic [15:0]             batch_count,
  output logic                    status,
  output logic                    last
);

  // The controller sequences the divisions, the walk and the emission; the
  // datapath holds all registers that carry values.
  pgwb_pkg::cmd_t  cmd;
  pgwb_pkg::stat_t stat;

  pgwb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .kind        (kind),
    .last_vertex (last_vertex),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  pgwb_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .polygon_id     (polygon_id),
    .vertex_x       (vertex_x),
    .vertex_y       (vertex_y),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_polygon_id (out_polygon_id),
    .worker         (worker),
    .flush          (flush),
    .batch_count    (batch_count),
    .status         (status),
    .last           (last)
  );

endmodule

`default_nettype wire
